// ===== design/spsq_pkg.sv =====
package spsq_pkg;

  // fixed field widths
  localparam int unsigned ACT_W        = 2;
  localparam int unsigned COUNT_W      = 32;
  localparam int unsigned COIL_W       = 5;
  localparam int unsigned PHASE_W      = 4;
  localparam int unsigned STAT_W       = 2;
  localparam int unsigned CFG_ADDR_W   = 2;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned OUT_TDATA_W  = 16;
  localparam int unsigned TIME_WIDTH_DEF = 26;

  // serial divider sizes: dividend up to 60e6 fits 26 bits, divisors are 16 bits
  localparam int unsigned DIV_W   = 26;
  localparam int unsigned DSR_W   = 16;
  localparam int unsigned DCNT_W  = $clog2(DIV_W);
  localparam logic [DIV_W-1:0] US_PER_MINUTE = DIV_W'(60000000);

  // item kinds
  localparam logic [ACT_W-1:0] ACT_TICK    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_MOVE    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_UNCFG = 2'd1;
  localparam logic [STAT_W-1:0] ST_BUSY  = 2'd2;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_WIRE_MODE = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SPR       = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_RPM       = 2'd2;

  // wire modes
  localparam logic [1:0] WM_NONE = 2'd0;
  localparam logic [1:0] WM_TWO  = 2'd1;
  localparam logic [1:0] WM_FOUR = 2'd2;
  localparam logic [1:0] WM_FIVE = 2'd3;

  localparam logic [15:0] SPR_RESET = 16'd200;

  // controller states
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV1  = 5'b00010,
    S_INIT2 = 5'b00100,
    S_DIV2  = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic exec_short;
    logic div_init1;
    logic div_init2;
    logic div_step;
    logic commit;
  } spsq_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic move_long;
  } spsq_stat_t;

  // coil mask lookup with clamping to the last entry
  function automatic logic [COIL_W-1:0] coil_mask(input logic [1:0] wm,
                                                  input logic [PHASE_W-1:0] ph);
    logic [COIL_W-1:0] m;
    m = '0;
    case (wm)
      WM_TWO: begin
        case (ph)
          4'd0:    m = 5'h02;
          4'd1:    m = 5'h03;
          4'd2:    m = 5'h01;
          default: m = 5'h00;
        endcase
      end
      WM_FOUR: begin
        case (ph)
          4'd0:    m = 5'h05;
          4'd1:    m = 5'h06;
          4'd2:    m = 5'h0a;
          default: m = 5'h09;
        endcase
      end
      default: begin
        case (ph)
          4'd0:    m = 5'h16;
          4'd1:    m = 5'h12;
          4'd2:    m = 5'h1a;
          4'd3:    m = 5'h0a;
          4'd4:    m = 5'h0b;
          4'd5:    m = 5'h09;
          4'd6:    m = 5'h0d;
          4'd7:    m = 5'h05;
          4'd8:    m = 5'h15;
          default: m = 5'h14;
        endcase
      end
    endcase
    return m;
  endfunction

endpackage

// ===== design/spsq_ctrl.sv =====
module spsq_ctrl
  import spsq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic       out_tready,
  input  spsq_stat_t dp_stat,
  output spsq_cmd_t  cmd,
  output logic       in_tready,
  output logic       out_tvalid
);

  state_t            state_r, state_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              last_iter;

  assign last_iter  = (cnt_r == DCNT_W'(DIV_W - 1));
  assign in_tready  = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;

  // sequencing of one item
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (dp_stat.move_long) begin
            cmd.div_init1 = 1'b1;
            cnt_nxt       = '0;
            state_nxt     = S_DIV1;
          end else begin
            cmd.exec_short = 1'b1;
            out_valid_nxt  = 1'b1;
          end
        end
      end
      S_DIV1: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (last_iter) begin
          state_nxt = S_INIT2;
        end
      end
      S_INIT2: begin
        cmd.div_init2 = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = S_DIV2;
      end
      S_DIV2: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (last_iter) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.commit    = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== design/spsq_dp.sv =====
module spsq_dp
  import spsq_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic [ACT_W-1:0]       in_action,
  input  logic [COUNT_W-1:0]     in_count,
  input  spsq_cmd_t              cmd,
  output spsq_stat_t             dp_stat,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  // configuration
  logic [1:0]            wire_mode_r;
  logic [15:0]           spr_r;
  logic [15:0]           rpm_r;
  // motion state
  logic [PHASE_W-1:0]    phase_r, phase_nxt;
  logic [COIL_W-1:0]     coil_r, coil_nxt;
  logic [COUNT_W-1:0]    steps_left_r, steps_left_nxt;
  logic                  rev_r, rev_nxt;
  logic [TIME_WIDTH-1:0] elapsed_r, elapsed_nxt;
  logic [TIME_WIDTH-1:0] period_r, period_nxt;
  // held move and divider
  logic [COUNT_W-1:0]    pend_count_r;
  logic                  pend_rev_r;
  logic [DIV_W-1:0]      quo_r;
  logic [DSR_W:0]        rem_r;
  logic [DSR_W-1:0]      dsr_r;
  // result register
  logic [OUT_TDATA_W-1:0] out_r;

  logic [STAT_W-1:0]     move_stat;
  logic                  busy;
  logic [TIME_WIDTH-1:0] elapsed_inc;
  logic                  do_step;
  logic [PHASE_W-1:0]    ph_count;
  logic [PHASE_W-1:0]    ph_step;
  logic [DSR_W:0]        rem_sh;
  logic [DSR_W:0]        rem_diff;
  logic                  rem_ge;
  logic [DIV_W-1:0]      period_q;
  logic                  res_stepped;
  logic [STAT_W-1:0]     res_stat;

  assign busy = (steps_left_r != '0);

  // move admission check
  always_comb begin
    if (wire_mode_r == WM_NONE || rpm_r == '0) begin
      move_stat = ST_UNCFG;
    end else if (busy) begin
      move_stat = ST_BUSY;
    end else begin
      move_stat = ST_OK;
    end
  end

  assign dp_stat.move_long = (in_action == ACT_MOVE) && (move_stat == ST_OK) &&
                             (in_count != '0);

  // saturating tick count and step decision
  assign elapsed_inc = (elapsed_r == '1) ? elapsed_r : elapsed_r + 1'b1;
  assign do_step     = busy && (elapsed_inc >= period_r);

  // next phase, wrapping over 4 or 10
  assign ph_count = (wire_mode_r == WM_FIVE) ? PHASE_W'(10) : PHASE_W'(4);
  always_comb begin
    if (!rev_r) begin
      ph_step = (phase_r + 1'b1 >= ph_count) ? '0 : phase_r + 1'b1;
    end else if (phase_r == '0 || phase_r >= ph_count) begin
      ph_step = ph_count - 1'b1;
    end else begin
      ph_step = phase_r - 1'b1;
    end
  end

  // restoring divider step
  assign rem_sh   = {rem_r[DSR_W-1:0], quo_r[DIV_W-1]};
  assign rem_diff = rem_sh - {1'b0, dsr_r};
  assign rem_ge   = (rem_sh >= {1'b0, dsr_r});
  assign period_q = (quo_r == '0) ? DIV_W'(1) : quo_r;

  // state updates for short items, move commit and config writes
  always_comb begin
    phase_nxt      = phase_r;
    coil_nxt       = coil_r;
    steps_left_nxt = steps_left_r;
    rev_nxt        = rev_r;
    elapsed_nxt    = elapsed_r;
    period_nxt     = period_r;
    res_stepped    = 1'b0;
    res_stat       = ST_OK;
    if (cmd.exec_short) begin
      case (in_action)
        ACT_TICK: begin
          elapsed_nxt = elapsed_inc;
          if (do_step) begin
            phase_nxt      = ph_step;
            coil_nxt       = coil_mask(wire_mode_r, ph_step);
            steps_left_nxt = steps_left_r - 1'b1;
            elapsed_nxt    = '0;
            res_stepped    = 1'b1;
          end
        end
        ACT_MOVE: begin
          res_stat = move_stat;
        end
        ACT_RELEASE: begin
          coil_nxt       = '0;
          steps_left_nxt = '0;
        end
        default: begin
        end
      endcase
    end
    if (cmd.commit) begin
      period_nxt     = TIME_WIDTH'(period_q);
      rev_nxt        = pend_rev_r;
      steps_left_nxt = pend_count_r;
    end
    if (cfg_we) begin
      case (cfg_addr)
        REG_WIRE_MODE: begin
          phase_nxt      = '0;
          coil_nxt       = '0;
          steps_left_nxt = '0;
          elapsed_nxt    = '0;
        end
        REG_SPR, REG_RPM: begin
          elapsed_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // architectural registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wire_mode_r  <= WM_NONE;
      spr_r        <= SPR_RESET;
      rpm_r        <= '0;
      phase_r      <= '0;
      coil_r       <= '0;
      steps_left_r <= '0;
      rev_r        <= 1'b0;
      elapsed_r    <= '0;
      period_r     <= '0;
    end else begin
      phase_r      <= phase_nxt;
      coil_r       <= coil_nxt;
      steps_left_r <= steps_left_nxt;
      rev_r        <= rev_nxt;
      elapsed_r    <= elapsed_nxt;
      period_r     <= period_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          REG_WIRE_MODE: wire_mode_r <= cfg_wdata[1:0];
          REG_SPR:       spr_r       <= cfg_wdata;
          REG_RPM:       rpm_r       <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // held move, divider and result payload
  always_ff @(posedge clk) begin
    if (cmd.div_init1) begin
      pend_rev_r   <= in_count[COUNT_W-1];
      pend_count_r <= in_count[COUNT_W-1] ? (~in_count + 1'b1) : in_count;
      quo_r        <= US_PER_MINUTE;
      rem_r        <= '0;
      dsr_r        <= (spr_r == '0) ? DSR_W'(1) : spr_r;
    end else if (cmd.div_init2) begin
      rem_r <= '0;
      dsr_r <= rpm_r;
    end else if (cmd.div_step) begin
      rem_r <= rem_ge ? rem_diff : rem_sh;
      quo_r <= {quo_r[DIV_W-2:0], rem_ge};
    end
    if (cmd.exec_short || cmd.commit) begin
      out_r <= OUT_TDATA_W'({res_stat, (steps_left_nxt != '0), res_stepped, coil_nxt});
    end
  end

  assign out_tdata = out_r;

endmodule

// ===== design/stepper_phase_sequencer_top.sv =====
// stepper phase sequencer: one result item per input item
// tick, release, zero-count or rejected move: result next cycle, 1 item per cycle while out_tready
// started move: period set by two passes of the 26-bit serial divider (one bit a cycle)
// a new item is taken only with the divider idle and the result register empty or being read
// rst_n synchronous active low: coils low, no move, registers to mode none, 200 steps, 0 rpm
module stepper_phase_sequencer_top
  import spsq_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [COUNT_W-1:0]     in_tdata,   // step_count[31:0]
  input  logic [ACT_W-1:0]       in_tuser,   // action[1:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // coil_drive[4:0], stepped[5], moving[6], status[8:7]
);

  spsq_cmd_t  cmd;
  spsq_stat_t dp_stat;
  logic       in_fire;

  assign in_fire = in_tvalid && in_tready;

  spsq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .out_tready (out_tready),
    .dp_stat    (dp_stat),
    .cmd        (cmd),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid)
  );

  spsq_dp #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_action (in_tuser),
    .in_count  (in_tdata),
    .cmd       (cmd),
    .dp_stat   (dp_stat),
    .out_tdata (out_tdata)
  );

endmodule
